FILE: hdl/tws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg
// shared constants and codes of the timing wheel scheduler
// ----------------------------------------------------------------------------
package tws_pkg;
  localparam int unsigned SlotsDef   = 64;
  localparam int unsigned SliceDef   = 16;
  localparam int unsigned EntriesDef = 256;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned IdW     = 16;
  localparam int unsigned WaitW   = 20;
  localparam int unsigned StatW   = 2;
  localparam int unsigned RemW    = 21;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned LeftW   = 22;

  localparam logic [FuncW-1:0] FuncAdd = 2'd0;
  localparam logic [FuncW-1:0] FuncGet = 2'd1;
  localparam logic [FuncW-1:0] FuncRem = 2'd2;

  localparam logic [StatW-1:0] StatOk    = 2'd0;
  localparam logic [StatW-1:0] StatEmpty = 2'd1;
  localparam logic [StatW-1:0] StatFull  = 2'd2;
  localparam logic [StatW-1:0] StatNoDue = 2'd3;
endpackage

FILE: hdl/tws_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_req_if / tws_rsp_if
// valid/ready channels of the timing wheel scheduler
// ----------------------------------------------------------------------------
interface tws_req_if;
  logic                        valid;
  logic                        ready;
  logic [tws_pkg::FuncW-1:0]   func;
  logic [tws_pkg::IdW-1:0]     obj_id;
  logic [tws_pkg::WaitW-1:0]   wait_time;
  modport source (output valid, func, obj_id, wait_time, input ready);
  modport sink   (input valid, func, obj_id, wait_time, output ready);
endinterface

interface tws_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [tws_pkg::StatW-1:0]         status;
  logic [tws_pkg::IdW-1:0]           due_id;
  logic signed [tws_pkg::RemW-1:0]   due_remaining;
  logic [tws_pkg::TimeW-1:0]         now_time;
  modport source (output valid, status, due_id, due_remaining, now_time, input ready);
  modport sink   (input valid, status, due_id, due_remaining, now_time, output ready);
endinterface

FILE: hdl/tws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_ram
// simple dual port synchronous ram (one write, one read port), registered read
// ----------------------------------------------------------------------------
module tws_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: hdl/timing_wheel_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timing_wheel_scheduler_unit
// hashed timing wheel: slot fifos as linked lists in a shared entry pool
// ----------------------------------------------------------------------------
// channel   dir  fields                                       handshake
// req_if    in   func, obj_id, wait_time                      valid/ready
// rsp_if    out  status, due_id, due_remaining, now_time      valid/ready
//
// one request at a time; add passes free-head read, shift, divide (skipped when
// capped), entry write and tail link; remove reads the front and pops it if due;
// pool full, empty wheel, empty slot on remove or unused code go straight to the
// respond state; get walks empty slots and re-places each front entry not yet due
// after reset a clearing pass over all Entries links builds the free chain
// (request ready stays low), slot busy bits are flip-flops cleared at once
// the output register holds a result until taken; the next request enters
// meanwhile, and its result waits in the respond state while the register is full
// ----------------------------------------------------------------------------
module timing_wheel_scheduler_unit #(
  parameter int unsigned Slots   = tws_pkg::SlotsDef,
  parameter int unsigned Slice   = tws_pkg::SliceDef,
  parameter int unsigned Entries = tws_pkg::EntriesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  tws_req_if.sink   req_if,
  tws_rsp_if.source rsp_if
);
  localparam int unsigned SW = $clog2(Slots);
  localparam int unsigned EW = $clog2(Entries);
  localparam int unsigned LW = tws_pkg::LeftW;
  localparam int unsigned TW = tws_pkg::TimeW;
  localparam int unsigned CW = EW + 1;
  localparam logic signed [LW-1:0] Cap = LW'(Slice * (Slots - 1));
  localparam logic [TW-1:0] EmptyAdv =
    TW'(64'(Slots) * 64'(Slots) * 64'(Slice) + 64'(Slots) * 64'(Slice));
  localparam int unsigned ShW = SW + 1;
  // reciprocal of the slice, exact for every time below the cap
  localparam int unsigned MulK = 2 * $clog2(Slice) + $clog2(Slots);
  localparam longint unsigned MulM = (64'd1 << MulK) / 64'(Slice) + 64'd1;
  localparam int unsigned MW = $clog2(MulM + 64'd1);

  // state codes
  localparam logic [3:0] StInit = 4'd0;
  localparam logic [3:0] StIdle = 4'd1;
  localparam logic [3:0] StAddA = 4'd2;  // read link of free head
  localparam logic [3:0] StAddB = 4'd3;
  localparam logic [3:0] StPlc  = 4'd4;  // compute shift, divide
  localparam logic [3:0] StApp  = 4'd5;  // write entry, read last of slot
  localparam logic [3:0] StWalk = 4'd6;  // check busy of wheel pos
  localparam logic [3:0] StRdF  = 4'd7;  // read front entry
  localparam logic [3:0] StChk  = 4'd8;
  localparam logic [3:0] StPop  = 4'd9;  // unused, goes back to idle
  localparam logic [3:0] StPopB = 4'd10;
  localparam logic [3:0] StRsp  = 4'd11;
  localparam logic [3:0] StDiv  = 4'd12;

  logic [3:0] st_q, st_d;

  // memories: entry id+left, entry link, slot first, slot last
  logic          ent_we;  logic [EW-1:0] ent_wa, ent_ra;
  logic [tws_pkg::IdW+LW-1:0] ent_wd, ent_rd;
  logic          lnk_we;  logic [EW-1:0] lnk_wa, lnk_ra, lnk_wd, lnk_rd;
  logic          sf_we;   logic [SW-1:0] sf_wa, sf_ra; logic [EW-1:0] sf_wd, sf_rd;
  logic          sl_we;   logic [SW-1:0] sl_wa, sl_ra; logic [EW-1:0] sl_wd, sl_rd;

  tws_ram #(.Width(tws_pkg::IdW + LW), .Depth(Entries)) u_ent (
    .clk_i, .we_i(ent_we), .waddr_i(ent_wa), .wdata_i(ent_wd),
    .raddr_i(ent_ra), .rdata_o(ent_rd));
  tws_ram #(.Width(EW), .Depth(Entries)) u_lnk (
    .clk_i, .we_i(lnk_we), .waddr_i(lnk_wa), .wdata_i(lnk_wd),
    .raddr_i(lnk_ra), .rdata_o(lnk_rd));
  tws_ram #(.Width(EW), .Depth(Slots)) u_sf (
    .clk_i, .we_i(sf_we), .waddr_i(sf_wa), .wdata_i(sf_wd),
    .raddr_i(sf_ra), .rdata_o(sf_rd));
  tws_ram #(.Width(EW), .Depth(Slots)) u_sl (
    .clk_i, .we_i(sl_we), .waddr_i(sl_wa), .wdata_i(sl_wd),
    .raddr_i(sl_ra), .rdata_o(sl_rd));

  logic [Slots-1:0] busy_q, busy_d;
  logic [EW-1:0]    free_q, free_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [SW-1:0]    pos_q, pos_d;
  logic [TW-1:0]    time_q, time_d;
  logic [EW-1:0]    init_q, init_d;

  // working registers
  logic [tws_pkg::FuncW-1:0] func_q, func_d;
  logic [tws_pkg::IdW-1:0]   id_q, id_d;
  logic signed [LW-1:0]      t_q, t_d;      // time to place
  logic [EW-1:0]             e_q, e_d;      // entry being handled
  logic [ShW-1:0]            sh_q, sh_d;    // shift
  logic [LW-1:0]             rem_q, rem_d;  // pop flags: bit1 pop, bit0 last in slot
  logic [SW-1:0]             idx_q, idx_d;

  logic [tws_pkg::StatW-1:0] os_q, os_d;
  logic [tws_pkg::IdW-1:0]   oi_q, oi_d;
  logic signed [tws_pkg::RemW-1:0] or_q, or_d;

  // output register
  logic                      ov_q, ov_d;
  logic [tws_pkg::StatW-1:0] ost_q, ost_d;
  logic [tws_pkg::IdW-1:0]   oid_q, oid_d;
  logic signed [tws_pkg::RemW-1:0] orm_q, orm_d;
  logic [TW-1:0]             onow_q, onow_d;

  logic signed [LW-1:0] fr_left;
  logic [tws_pkg::IdW-1:0] fr_id;
  logic [SW:0] idx_sum;
  logic [LW+MW-1:0] quo_prod;

  assign fr_id   = ent_rd[tws_pkg::IdW+LW-1:LW];
  assign fr_left = $signed(ent_rd[LW-1:0]);
  assign idx_sum = {1'b0, pos_q} + sh_q[SW:0];
  assign quo_prod = (LW+MW)'($unsigned(t_q)) * (LW+MW)'(MulM);

  assign req_if.ready = (st_q == StIdle);
  assign rsp_if.valid = ov_q;
  assign rsp_if.status = ost_q;
  assign rsp_if.due_id = oid_q;
  assign rsp_if.due_remaining = orm_q;
  assign rsp_if.now_time = onow_q;

  always_comb begin
    st_d = st_q; busy_d = busy_q; free_d = free_q; cnt_d = cnt_q;
    pos_d = pos_q; time_d = time_q; init_d = init_q;
    func_d = func_q; id_d = id_q; t_d = t_q; e_d = e_q; sh_d = sh_q;
    rem_d = rem_q; idx_d = idx_q;
    os_d = os_q; oi_d = oi_q; or_d = or_q;
    ov_d = ov_q; ost_d = ost_q; oid_d = oid_q; orm_d = orm_q; onow_d = onow_q;
    ent_we = 1'b0; ent_wa = e_q; ent_wd = {id_q, t_q}; ent_ra = e_q;
    lnk_we = 1'b0; lnk_wa = e_q; lnk_wd = e_q; lnk_ra = e_q;
    sf_we = 1'b0; sf_wa = idx_q; sf_wd = e_q; sf_ra = pos_q;
    sl_we = 1'b0; sl_wa = idx_q; sl_wd = e_q; sl_ra = idx_q;
    if (ov_q && rsp_if.ready) ov_d = 1'b0;
    unique case (st_q)
      StInit: begin
        lnk_we = 1'b1; lnk_wa = init_q; lnk_wd = init_q + EW'(1);
        init_d = init_q + EW'(1);
        if (init_q == EW'(Entries - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (req_if.valid) begin
          func_d = req_if.func; id_d = req_if.obj_id;
          t_d = LW'(req_if.wait_time);
          os_d = tws_pkg::StatOk; oi_d = '0; or_d = '0;
          unique case (req_if.func)
            tws_pkg::FuncAdd: begin
              if (cnt_q == '0) begin
                os_d = tws_pkg::StatFull; st_d = StRsp;
              end else begin
                e_d = free_q; lnk_ra = free_q; st_d = StAddA;
              end
            end
            tws_pkg::FuncGet: begin
              if (cnt_q == CW'(Entries)) begin
                time_d = time_q + EmptyAdv - TW'(pos_q) * TW'(Slice);
                pos_d = '0; os_d = tws_pkg::StatEmpty; st_d = StRsp;
              end else st_d = StWalk;
            end
            tws_pkg::FuncRem: begin
              if (!busy_q[pos_q]) begin
                os_d = tws_pkg::StatNoDue; st_d = StRsp;
              end else st_d = StWalk;
            end
            default: st_d = StRsp;
          endcase
        end
      end
      StAddA: st_d = StAddB;
      StAddB: begin
        free_d = lnk_rd; cnt_d = cnt_q - CW'(1); st_d = StPlc;
      end
      StPlc: begin
        // shift is capped, or the slice quotient plus one
        if (t_q >= LW'(Cap)) begin
          sh_d = ShW'(Slots - 1); st_d = StApp;
          t_d = t_q - LW'(Cap);
        end else begin
          sh_d = ShW'(quo_prod >> MulK) + ShW'(1); st_d = StDiv;
        end
      end
      StDiv: begin
        // time left after shift slices
        t_d = t_q - LW'(sh_q * Slice); st_d = StApp;
      end
      StApp: begin
        // idx ready: read last of slot
        idx_d = (idx_sum >= (SW+1)'(Slots)) ? SW'(idx_sum - (SW+1)'(Slots))
                                           : SW'(idx_sum);
        sl_ra = (idx_sum >= (SW+1)'(Slots)) ? SW'(idx_sum - (SW+1)'(Slots))
                                           : SW'(idx_sum);
        ent_we = 1'b1; ent_wa = e_q; ent_wd = {id_q, t_q};
        st_d = StPopB;
        rem_d = '0;
      end
      StPopB: begin
        if (rem_q == '0) begin
          // append: sl_rd valid now
          if (busy_q[idx_q]) begin
            lnk_we = 1'b1; lnk_wa = sl_rd; lnk_wd = e_q;
          end else begin
            sf_we = 1'b1; sf_wa = idx_q; sf_wd = e_q;
            busy_d[idx_q] = 1'b1;
          end
          sl_we = 1'b1; sl_wa = idx_q; sl_wd = e_q;
          st_d = (func_q == tws_pkg::FuncAdd) ? StRsp : StWalk;
        end else begin
          // pop finish: lnk_rd is link of front
          if (rem_q[0]) begin
            busy_d[pos_q] = 1'b0;
          end else begin
            sf_we = 1'b1; sf_wa = pos_q; sf_wd = lnk_rd;
          end
          if (func_q == tws_pkg::FuncRem) begin
            lnk_we = 1'b1; lnk_wa = e_q; lnk_wd = free_q;
            free_d = e_q; cnt_d = cnt_q + CW'(1); st_d = StRsp;
          end else begin
            t_d = fr_left; st_d = StPlc;
          end
        end
      end
      StWalk: begin
        if (!busy_q[pos_q]) begin
          time_d = time_q + TW'(Slice);
          pos_d = (pos_q == SW'(Slots - 1)) ? '0 : pos_q + SW'(1);
        end else begin
          sf_ra = pos_q; sl_ra = pos_q; st_d = StRdF;
        end
      end
      StRdF: begin
        e_d = sf_rd; ent_ra = sf_rd; lnk_ra = sf_rd;
        rem_d = {{(LW-1){1'b0}}, (sf_rd == sl_rd)} | LW'(2);
        st_d = StChk;
      end
      StChk: begin
        // entry data, link of front valid
        id_d = fr_id;
        if (fr_left < 0) begin
          if (func_q == tws_pkg::FuncGet) begin
            oi_d = fr_id; or_d = tws_pkg::RemW'(fr_left); st_d = StRsp;
          end else begin
            oi_d = fr_id; or_d = tws_pkg::RemW'(fr_left); st_d = StPopB;
          end
        end else if (func_q == tws_pkg::FuncRem) begin
          os_d = tws_pkg::StatNoDue; st_d = StRsp;
        end else begin
          st_d = StPopB;
        end
        // keep entry data for replace
      end
      StPop: st_d = StIdle;
      StRsp: begin
        // load the output register once it is free or being emptied
        if (!ov_q || rsp_if.ready) begin
          ov_d = 1'b1; ost_d = os_q; oid_d = oi_q; orm_d = or_q; onow_d = time_q;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StInit; busy_q <= '0; free_q <= '0; cnt_q <= CW'(Entries);
      pos_q <= '0; time_q <= '0; init_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; busy_q <= busy_d; free_q <= free_d; cnt_q <= cnt_d;
      pos_q <= pos_d; time_q <= time_d; init_q <= init_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; id_q <= id_d; t_q <= t_d; e_q <= e_d; sh_q <= sh_d;
    rem_q <= rem_d; idx_q <= idx_d; os_q <= os_d; oi_q <= oi_d; or_q <= or_d;
    ost_q <= ost_d; oid_q <= oid_d; orm_q <= orm_d; onow_q <= onow_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Entries)) else $error("free count out of range");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_if.ready |-> (st_q == StIdle)) else $error("ready outside idle");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !rsp_if.ready) |=> ov_q && $stable(ost_q) && $stable(onow_q))
    else $error("result dropped");
endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the timing wheel scheduler: a directed table of
// requests, then random add/get/remove traffic with a pool-fill burst, all
// checked field by field against fixed table results or an in-bench model of
// the wheel, under changing idle and stall patterns on both channels
// ----------------------------------------------------------------------------
module tb;
  localparam int unsigned NSlot  = tws_pkg::SlotsDef;
  localparam int unsigned NSlice = tws_pkg::SliceDef;
  localparam int unsigned NEntry = tws_pkg::EntriesDef;
  localparam longint unsigned CycleLimit = 64'd20_000_000;
  localparam int unsigned OweDepth = 16;
  localparam int unsigned TabDepth = 32;

  typedef struct {
    logic [tws_pkg::StatW-1:0]        st;
    logic [tws_pkg::IdW-1:0]          id;
    logic signed [tws_pkg::RemW-1:0]  rem;
    logic [tws_pkg::TimeW-1:0]        now;
  } wheel_rsp_t;

  typedef struct {
    logic [tws_pkg::FuncW-1:0] func;
    logic [tws_pkg::IdW-1:0]   id;
    logic [tws_pkg::WaitW-1:0] wt;
    bit                        typed;
    wheel_rsp_t                res;
  } req_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tws_req_if req_if ();
  tws_rsp_if rsp_if ();

  timing_wheel_scheduler_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_if),
    .rsp_if (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // wheel model state
  // ---------------------------------------------------------------------------
  logic [tws_pkg::IdW-1:0] ent_id [NEntry];
  int             ent_left [NEntry];
  int unsigned    ent_next [NEntry];
  int unsigned    slot_head[NSlot];
  int unsigned    slot_tail[NSlot];
  bit             slot_used[NSlot];
  int unsigned    free_head, free_cnt, wheel_at;
  logic [31:0]    wheel_now;

  // results still owed by the block, in request order
  wheel_rsp_t  owed [OweDepth];
  int unsigned owe_wr = 0, owe_rd = 0;
  int         n_mismatch = 0;
  int         n_taken = 0;
  int         n_add = 0, n_get = 0, n_rem = 0, n_full = 0, n_empty = 0;
  int         gap_pct = 0, stall_pct = 0;
  bit         rsp_hold = 1'b0;
  bit         pressure_go = 1'b0;

  function automatic void wheel_clear();
    for (int i = 0; i < NEntry; i++) ent_next[i] = i + 1;
    for (int s = 0; s < NSlot; s++) slot_used[s] = 1'b0;
    free_head = 0;
    free_cnt  = NEntry;
    wheel_at  = 0;
    wheel_now = '0;
  endfunction

  // append entry to a slot fifo at the position its remaining time calls for
  function automatic void slot_place(int unsigned e, int t);
    int          shift;
    int unsigned idx;
    shift = (t < int'(NSlice * (NSlot - 1))) ? t / int'(NSlice) + 1 : int'(NSlot - 1);
    idx = (wheel_at + shift) % NSlot;
    ent_left[e] = t - shift * int'(NSlice);
    if (slot_used[idx]) begin
      ent_next[slot_tail[idx]] = e;
      slot_tail[idx] = e;
    end else begin
      slot_head[idx] = e;
      slot_tail[idx] = e;
      slot_used[idx] = 1'b1;
    end
  endfunction

  function automatic int unsigned slot_take(int unsigned s);
    int unsigned f;
    f = slot_head[s];
    if (f == slot_tail[s]) slot_used[s] = 1'b0;
    else slot_head[s] = ent_next[f];
    return f;
  endfunction

  // one request through the wheel model
  function automatic wheel_rsp_t wheel_apply(logic [tws_pkg::FuncW-1:0] f,
                                             logic [tws_pkg::IdW-1:0] id,
                                             logic [tws_pkg::WaitW-1:0] wt);
    wheel_rsp_t  r;
    int unsigned e;
    r = '{st: tws_pkg::StatOk, id: '0, rem: '0, now: '0};
    if (f == tws_pkg::FuncAdd) begin
      if (free_cnt == 0) begin
        r.st = tws_pkg::StatFull;
      end else begin
        e = free_head;
        free_head = ent_next[e];
        free_cnt--;
        ent_id[e] = id;
        slot_place(e, int'(wt));
      end
    end else if (f == tws_pkg::FuncGet) begin
      if (free_cnt == NEntry) begin
        // empty wheel: walk until the wheel has wrapped slots+1 times
        wheel_now += ((NSlot - wheel_at) + NSlot * NSlot) * NSlice;
        wheel_at = 0;
        r.st = tws_pkg::StatEmpty;
      end else begin
        forever begin
          while (!slot_used[wheel_at]) begin
            wheel_now += NSlice;
            wheel_at = (wheel_at + 1) % NSlot;
          end
          e = slot_head[wheel_at];
          if (ent_left[e] < 0) begin
            r.id  = ent_id[e];
            r.rem = tws_pkg::RemW'(ent_left[e]);
            break;
          end
          void'(slot_take(wheel_at));
          slot_place(e, ent_left[e]);
        end
      end
    end else if (f == tws_pkg::FuncRem) begin
      if (slot_used[wheel_at] && ent_left[slot_head[wheel_at]] < 0) begin
        e = slot_take(wheel_at);
        r.id  = ent_id[e];
        r.rem = tws_pkg::RemW'(ent_left[e]);
        ent_next[e] = free_head;
        free_head = e;
        free_cnt++;
      end else begin
        r.st = tws_pkg::StatNoDue;
      end
    end
    r.now = wheel_now;
    return r;
  endfunction

  function automatic void owe_put(wheel_rsp_t r);
    owed[owe_wr % OweDepth] = r;
    owe_wr++;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  task automatic send_req(req_row_t row);
    wheel_rsp_t r;
    while ($urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.func      <= row.func;
    req_if.obj_id    <= row.id;
    req_if.wait_time <= row.wt;
    do @(posedge clk_i); while (!req_if.ready);
    // accepted at this edge: advance the model in request order
    r = wheel_apply(row.func, row.id, row.wt);
    owe_put(row.typed ? row.res : r);
    case (row.func)
      tws_pkg::FuncAdd: n_add++;
      tws_pkg::FuncGet: n_get++;
      tws_pkg::FuncRem: n_rem++;
      default: ;
    endcase
  endtask

  // short waits keep the walks cheap; a rare full-range wait exercises high bits
  function automatic logic [tws_pkg::WaitW-1:0] pick_wait();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 85) return tws_pkg::WaitW'($urandom_range(0, 300));
    if (p < 99) return tws_pkg::WaitW'($urandom_range(0, 4095));
    return tws_pkg::WaitW'($urandom_range(0, 20'hFFFFF));
  endfunction

  function automatic req_row_t mk(logic [tws_pkg::FuncW-1:0] f, logic [tws_pkg::IdW-1:0] id,
                                  logic [tws_pkg::WaitW-1:0] wt);
    req_row_t row;
    row = '{func: f, id: id, wt: wt, typed: 1'b0,
            res: '{st: tws_pkg::StatOk, id: '0, rem: '0, now: '0}};
    return row;
  endfunction

  function automatic req_row_t mk_typed(logic [tws_pkg::FuncW-1:0] f,
                                        logic [tws_pkg::IdW-1:0] id,
                                        logic [tws_pkg::WaitW-1:0] wt,
                                        logic [tws_pkg::StatW-1:0] st,
                                        logic [tws_pkg::IdW-1:0] rid, int rem,
                                        logic [31:0] now);
    req_row_t row;
    row = '{func: f, id: id, wt: wt, typed: 1'b1,
            res: '{st: st, id: rid, rem: tws_pkg::RemW'(rem), now: now}};
    return row;
  endfunction

  // idle pattern follows the request count: none, sender, receiver, both
  function automatic void set_idling(int n);
    case ((n / 40) % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 48; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 48; end
      default: begin gap_pct = 11; stall_pct = 11; end
    endcase
  endfunction

  req_row_t dir_tab[TabDepth];
  int       n_dir = 0;

  function automatic void tab_add(req_row_t row);
    dir_tab[n_dir] = row;
    n_dir++;
  endfunction

  initial begin
    int       k;
    int       n_sent;
    req_row_t row;
    logic [tws_pkg::FuncW-1:0] f;

    req_if.valid     = 1'b0;
    req_if.func      = tws_pkg::FuncAdd;
    req_if.obj_id    = '0;
    req_if.wait_time = '0;
    wheel_clear();

    // directed table; empty-wheel walk: (64 + 64*64) slots of 16
    tab_add(mk_typed(tws_pkg::FuncGet, 16'h0, 20'h0, tws_pkg::StatEmpty, 16'h0, 0,
                     32'd66560));
    tab_add(mk_typed(tws_pkg::FuncRem, 16'h0, 20'h0, tws_pkg::StatNoDue, 16'h0, 0,
                     32'd66560));
    tab_add(mk_typed(2'd3, 16'hFFFF, 20'hFFFFF, tws_pkg::StatOk, 16'h0, 0, 32'd66560));
    tab_add(mk_typed(tws_pkg::FuncAdd, 16'hFFFF, 20'h0, tws_pkg::StatOk, 16'h0, 0,
                     32'd66560));
    tab_add(mk_typed(tws_pkg::FuncAdd, 16'h0000, 20'hFFFFF, tws_pkg::StatOk, 16'h0, 0,
                     32'd66560));
    // zero wait lands one slot ahead with remaining -16
    tab_add(mk_typed(tws_pkg::FuncGet, 16'h0, 20'h0, tws_pkg::StatOk, 16'hFFFF, -16,
                     32'd66576));
    tab_add(mk_typed(tws_pkg::FuncRem, 16'h0, 20'h0, tws_pkg::StatOk, 16'hFFFF, -16,
                     32'd66576));
    tab_add(mk_typed(tws_pkg::FuncRem, 16'h0, 20'h0, tws_pkg::StatNoDue, 16'h0, 0,
                     32'd66576));
    // slice boundaries and the cap at slots-1
    tab_add(mk(tws_pkg::FuncAdd, 16'h5555, 20'd15));
    tab_add(mk(tws_pkg::FuncAdd, 16'hAAAA, 20'd16));
    tab_add(mk(tws_pkg::FuncAdd, 16'h1234, 20'd1007));
    tab_add(mk(tws_pkg::FuncAdd, 16'h4321, 20'd1008));
    tab_add(mk(tws_pkg::FuncAdd, 16'h0F0F, 20'h55555));
    tab_add(mk(tws_pkg::FuncAdd, 16'hF0F0, 20'hAAAAA));
    for (int i = 0; i < 4; i++) begin
      tab_add(mk(tws_pkg::FuncGet, 16'h0, 20'h0));
      tab_add(mk(tws_pkg::FuncRem, 16'h0, 20'h0));
    end
    tab_add(mk(tws_pkg::FuncGet, 16'h0, 20'h0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    n_sent = 0;
    for (int i = 0; i < n_dir; i++) begin
      send_req(dir_tab[i]);
      n_sent++;
    end

    // mixed traffic: mostly add-then-collect sequences with some noise
    while (n_sent < 180) begin
      set_idling(n_sent);
      if (n_sent >= 60 && !pressure_go) pressure_go = 1'b1;
      if ($urandom_range(99) < 75) begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) begin
          send_req(mk(tws_pkg::FuncAdd, tws_pkg::IdW'($urandom), pick_wait()));
          n_sent++;
        end
        for (int i = 0; i < k; i++) begin
          send_req(mk(tws_pkg::FuncGet, tws_pkg::IdW'($urandom), tws_pkg::WaitW'($urandom)));
          send_req(mk(tws_pkg::FuncRem, tws_pkg::IdW'($urandom), tws_pkg::WaitW'($urandom)));
          n_sent += 2;
        end
      end else begin
        f = tws_pkg::FuncW'($urandom_range(0, 3));
        send_req(mk(f, tws_pkg::IdW'($urandom),
                    (f == tws_pkg::FuncAdd) ? pick_wait() : tws_pkg::WaitW'($urandom)));
        n_sent++;
      end
    end

    // fill the pool past its size so adds report full
    for (int i = 0; i < NEntry + 4; i++) begin
      set_idling(n_sent);
      send_req(mk(tws_pkg::FuncAdd, tws_pkg::IdW'($urandom),
                  tws_pkg::WaitW'($urandom_range(0, 200))));
      n_sent++;
    end

    // collect some back and mix again
    for (int i = 0; i < 40; i++) begin
      set_idling(n_sent);
      f = ($urandom_range(3) == 0) ? tws_pkg::FuncAdd :
          (i % 2 == 0) ? tws_pkg::FuncGet : tws_pkg::FuncRem;
      send_req(mk(f, tws_pkg::IdW'($urandom), tws_pkg::WaitW'($urandom_range(0, 200))));
      n_sent++;
    end

    req_if.valid <= 1'b0;
    wait (owe_wr == owe_rd);
    repeat (50) @(posedge clk_i);
    $display("ran %0d requests: %0d add, %0d get, %0d remove, %0d results checked",
             n_sent, n_add, n_get, n_rem, n_taken);
    $display("saw %0d pool-full and %0d empty-wheel results, %0d mismatches",
             n_full, n_empty, n_mismatch);
    if (n_mismatch == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  // long hold-off on results while requests keep coming, so the input stalls
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    rsp_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rsp_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    wheel_rsp_t exp_r;
    if (rsp_if.valid && rsp_if.ready) begin
      n_taken++;
      if (owe_wr == owe_rd) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("result with nothing outstanding at %0t", $realtime);
      end else begin
        exp_r = owed[owe_rd % OweDepth];
        owe_rd++;
        if (exp_r.st == tws_pkg::StatFull) n_full++;
        if (exp_r.st == tws_pkg::StatEmpty) n_empty++;
        if (rsp_if.status !== exp_r.st || rsp_if.due_id !== exp_r.id ||
            rsp_if.due_remaining !== exp_r.rem || rsp_if.now_time !== exp_r.now) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch #%0d: exp st=%0d id=%h rem=%0d now=%0d, %s",
                     n_taken, exp_r.st, exp_r.id, exp_r.rem, exp_r.now,
                     $sformatf("got st=%0d id=%h rem=%0d now=%0d", rsp_if.status,
                               rsp_if.due_id, rsp_if.due_remaining, rsp_if.now_time));
        end
      end
    end
    rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  longint unsigned n_cycles = 0;
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               owe_wr - owe_rd);
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
